[src/mfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-hart fetch stage package
// Request and response types, hart pick record and register indexes for
// the fetch stage; the request and pick types also serve its hart control.
// ----------------------------------------------------------------------------
package mfs_pkg;

	localparam int PC_W      = 16;
	localparam int WORD_W    = 32;
	localparam int ADDR_W    = 14;
	localparam int MASK_W    = 4;
	localparam int HART_ID_W = 2;
	localparam int RUN_W     = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_START_PC      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RUNNING_HARTS = 2'd1;

	localparam logic [PC_W-1:0]  START_PC_RESET = 16'd0;
	localparam logic [RUN_W-1:0] RUNNING_RESET  = 3'd4;

	typedef enum logic [1:0] {
		KIND_CYCLE = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_START = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [MASK_W-1:0]     decode_full_mask;
		logic                  dec_redirect_valid;
		logic [HART_ID_W-1:0]  dec_redirect_hart;
		logic [PC_W-1:0]       dec_redirect_pc;
		logic                  exe_redirect_valid;
		logic [HART_ID_W-1:0]  exe_redirect_hart;
		logic [PC_W-1:0]       exe_redirect_pc;
		logic [ADDR_W-1:0]     load_address;
		logic [WORD_W-1:0]     load_word;
	} fetch_req_t;

	typedef struct packed {
		logic                  fetch_valid;
		logic [HART_ID_W-1:0]  fetch_hart;
		logic [PC_W-1:0]       fetch_pc;
		logic [WORD_W-1:0]     fetch_instruction;
	} fetch_rsp_t;

	// Outcome of the hart selection for one pipeline cycle.
	typedef struct packed {
		logic                  valid;
		logic [HART_ID_W-1:0]  hart;
		logic [PC_W-1:0]       pc;
	} hart_pick_t;

endpackage
`default_nettype wire

[src/mfs_hart_ctl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hart control
// Holds the full flag and pc of every hart, picks the hart to fetch and
// applies start requests and redirects.
// ----------------------------------------------------------------------------
module mfs_hart_ctl #(
	parameter int HART_COUNT = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire mfs_pkg::fetch_req_t req,
	input  wire logic [15:0]        start_pc,
	input  wire logic [2:0]         running_harts,
	output mfs_pkg::hart_pick_t     pick
);
	import mfs_pkg::*;

	localparam int HID_W = $clog2(HART_COUNT);
	localparam int CNT_W = $clog2(HART_COUNT + 1);
	localparam int BW    = (HART_COUNT > MASK_W) ? HART_COUNT : MASK_W;

	logic [HART_COUNT-1:0] full_q;
	logic [PC_W-1:0]       pc_q [HART_COUNT];
	logic [HART_COUNT-1:0] full_d;
	logic [PC_W-1:0]       pc_d [HART_COUNT];

	logic [BW-1:0]         mask_ext;
	logic [HART_COUNT-1:0] busy;
	logic [HART_COUNT-1:0] elig;
	logic [HART_COUNT-1:0] below_mask;
	logic [HART_COUNT-1:0] start_mask;
	logic [CNT_W-1:0]      run_n;
	logic [HID_W-1:0]      sel;
	logic [HID_W-1:0]      dec_idx;
	logic [HID_W-1:0]      exe_idx;
	logic                  dec_ok;
	logic                  exe_ok;

	// Harts above the mask width always see a free decode slot.
	assign mask_ext = BW'(req.decode_full_mask);
	assign busy     = mask_ext[HART_COUNT-1:0];
	assign elig     = full_q & ~busy;

	always_comb begin
		sel = '0;
		for (int h = HART_COUNT - 1; h >= 0; h--) begin
			if (elig[h]) begin
				sel = HID_W'(h);
			end
		end
	end

	assign below_mask = (HART_COUNT'(1) << sel) - HART_COUNT'(1);

	always_comb begin
		pick.valid = |elig;
		pick.hart  = (|elig) ? HART_ID_W'(sel) : '0;
		pick.pc    = (|elig) ? pc_q[sel] : '0;
	end

	always_comb begin
		if (int'(running_harts) > HART_COUNT) begin
			run_n = CNT_W'(HART_COUNT);
		end else begin
			run_n = CNT_W'(running_harts);
		end
		for (int h = 0; h < HART_COUNT; h++) begin
			start_mask[h] = (h < int'(run_n));
		end
	end

	assign dec_ok  = req.dec_redirect_valid && (int'(req.dec_redirect_hart) < HART_COUNT);
	assign exe_ok  = req.exe_redirect_valid && (int'(req.exe_redirect_hart) < HART_COUNT);
	assign dec_idx = HID_W'(req.dec_redirect_hart);
	assign exe_idx = HID_W'(req.exe_redirect_hart);

	always_comb begin
		full_d = full_q;
		pc_d   = pc_q;
		if (fire) begin
			case (req.kind)
				KIND_START: begin
					for (int h = 0; h < HART_COUNT; h++) begin
						full_d[h] = start_mask[h];
						if (start_mask[h]) begin
							pc_d[h] = start_pc;
						end
					end
				end
				KIND_CYCLE: begin
					if (|elig) begin
						full_d[sel] = 1'b0;
					end
					// Execute is applied last so that it wins on the same hart.
					if (dec_ok) begin
						full_d[dec_idx] = 1'b1;
						pc_d[dec_idx]   = req.dec_redirect_pc;
					end
					if (exe_ok) begin
						full_d[exe_idx] = 1'b1;
						pc_d[exe_idx]   = req.exe_redirect_pc;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
			for (int h = 0; h < HART_COUNT; h++) begin
				pc_q[h] <= '0;
			end
		end else begin
			full_q <= full_d;
			pc_q   <= pc_d;
		end
	end

	a_pick_eligible: assert property (@(posedge clk) disable iff (!arst_n)
		pick.valid |-> (full_q[sel] && !busy[sel]))
		else $error("picked hart is not fetchable");

	a_pick_lowest: assert property (@(posedge clk) disable iff (!arst_n)
		pick.valid |-> ((elig & below_mask) == '0))
		else $error("a lower hart was fetchable");

	a_start_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req.kind == KIND_START) |=> (full_q == $past(start_mask)))
		else $error("start did not set the running harts");

endmodule
`default_nettype wire

[src/multihart_fetch_stage_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-hart fetch stage
// Picks one ready hart per pipeline cycle and reads its code word from the
// code store; also loads code words and starts the harts.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on req_valid/req_ready with a fetch_req_t payload:
// a pipeline cycle, a code word load or a start of the harts. Only a
// pipeline cycle produces a response, on rsp_valid/rsp_ready, carrying
// the fetched hart, its pc and the instruction (all zero when no hart
// could be fetched). Loads and starts produce nothing.
// Configuration writes (start pc, running hart count) come in on
// cfg_valid/cfg_index/cfg_data; cfg_ready is always high. They should only
// be made while the stage is empty.
// A pipeline cycle passes the input register, the address stage and the
// code store read register before its response shows. Throughput: one
// request per clock while no stage is held. The hart flags are updated
// in the cycle a request leaves the input register, and the single-port
// code store does one load or one read per cycle.
// When the receiver stalls, the response register holds and the stages
// behind it keep filling; req_ready drops only once every stage is
// occupied. Loads and starts keep flowing past a stalled response where
// there is room.
// Reset clears the hart flags and pcs, sets the start pc to zero and the
// running count to four. The code store is not cleared: fetch from a
// word that was never loaded returns an undefined value.
// ----------------------------------------------------------------------------
module multihart_fetch_stage_unit #(
	parameter int HART_COUNT = 4,
	parameter int CODE_WORDS = 16384
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire mfs_pkg::fetch_req_t req_data,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output mfs_pkg::fetch_rsp_t      rsp_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data
);
	import mfs_pkg::*;

	// Code store index width, and the wider of it and the request address.
	localparam int AW = (CODE_WORDS > 1) ? $clog2(CODE_WORDS) : 1;
	localparam int IW = (AW > ADDR_W) ? AW : ADDR_W;

	// Addresses wrap modulo the store depth. The quotient is found by a
	// multiply with a rounded-up reciprocal, which is exact for every
	// address of ADDR_W bits; the remainder is then formed in stage 2.
	localparam int DIV_SH = ADDR_W + AW;
	localparam longint unsigned DIV_M =
		((64'd1 << DIV_SH) + longint'(CODE_WORDS) - 64'd1) / longint'(CODE_WORDS);
	localparam int MW = ADDR_W + 2;
	localparam int PW = ADDR_W + MW;
	localparam logic [MW-1:0]     DIV_MUL   = MW'(DIV_M);
	localparam logic [ADDR_W-1:0] DEPTH_LOW = ADDR_W'(CODE_WORDS);

	// Configuration registers.
	logic [PC_W-1:0]  start_pc_q;
	logic [RUN_W-1:0] running_harts_q;

	// Stage 1: input register.
	logic       v_s1;
	fetch_req_t req_s1;

	// Stage 2: code store address and quotient.
	logic              v_s2;
	kind_t             kind_s2;
	hart_pick_t        pick_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [ADDR_W-1:0] quo_s2;
	logic [WORD_W-1:0] word_s2;

	// Stage 3: response register, with the store read data.
	logic              v_s3;
	hart_pick_t        pick_s3;
	logic [WORD_W-1:0] rdata_s3;

	logic [WORD_W-1:0] code_ram [CODE_WORDS];

	hart_pick_t        pick;
	logic              go1;
	logic              go2;
	logic              r2;
	logic              r3;
	logic              pass2;
	logic [ADDR_W-1:0] addr_s1;
	logic [PW-1:0]     prod_s1;
	logic [ADDR_W-1:0] rem_s2;
	logic [IW-1:0]     rem_ext;
	logic [AW-1:0]     code_idx;
	logic              load_go;
	logic              read_go;

	// ------------------------------------------------------------------
	// Flow control: each stage moves on when the next one has room.
	// Loads finish in stage 2 and never need the response register.
	// ------------------------------------------------------------------
	assign r3        = !v_s3 || rsp_ready;
	assign go2       = v_s2 && ((kind_s2 != KIND_CYCLE) || r3);
	assign r2        = !v_s2 || go2;
	assign go1       = v_s1 && r2;
	assign req_ready = !v_s1 || go1;
	assign pass2     = go1 && ((req_s1.kind == KIND_CYCLE) || (req_s1.kind == KIND_LOAD));
	assign load_go   = go2 && (kind_s2 == KIND_LOAD);
	assign read_go   = go2 && (kind_s2 == KIND_CYCLE);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q      <= START_PC_RESET;
			running_harts_q <= RUNNING_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_START_PC:      start_pc_q      <= cfg_data;
				CFG_RUNNING_HARTS: running_harts_q <= cfg_data[RUN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: hart selection and state update happen as the request
	// leaves the input register, so the next request sees the result.
	// ------------------------------------------------------------------
	mfs_hart_ctl #(
		.HART_COUNT(HART_COUNT)
	) u_hart_ctl (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (go1),
		.req          (req_s1),
		.start_pc     (start_pc_q),
		.running_harts(running_harts_q),
		.pick         (pick)
	);

	// The word index of a fetch is the byte pc divided by four.
	assign addr_s1 = (req_s1.kind == KIND_LOAD) ? req_s1.load_address
		: pick.pc[PC_W-1:2];
	assign prod_s1 = PW'(addr_s1) * PW'(DIV_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (req_ready) begin
				v_s1 <= req_valid;
			end
			if (r2) begin
				v_s2 <= pass2;
			end
			if (read_go) begin
				v_s3 <= 1'b1;
			end else if (rsp_ready) begin
				v_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req_data;
		end
		if (pass2) begin
			kind_s2 <= req_s1.kind;
			pick_s2 <= pick;
			addr_s2 <= addr_s1;
			quo_s2  <= ADDR_W'(prod_s1 >> DIV_SH);
			word_s2 <= req_s1.load_word;
		end
		if (read_go) begin
			pick_s3 <= pick_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: remainder and code store access. The true remainder is
	// below 2**ADDR_W, so the arithmetic is done at that width.
	// ------------------------------------------------------------------
	assign rem_s2   = addr_s2 - quo_s2 * DEPTH_LOW;
	assign rem_ext  = IW'(rem_s2);
	assign code_idx = rem_ext[AW-1:0];

	always_ff @(posedge clk) begin
		if (load_go) begin
			code_ram[code_idx] <= word_s2;
		end
		if (read_go) begin
			rdata_s3 <= code_ram[code_idx];
		end
	end

	// ------------------------------------------------------------------
	// Response. An idle cycle reports zeros in every field.
	// ------------------------------------------------------------------
	assign rsp_valid = v_s3;

	always_comb begin
		rsp_data.fetch_valid       = pick_s3.valid;
		rsp_data.fetch_hart        = pick_s3.hart;
		rsp_data.fetch_pc          = pick_s3.pc;
		rsp_data.fetch_instruction = pick_s3.valid ? rdata_s3 : '0;
	end

endmodule
`default_nettype wire
